// ===== hdl/hue_gradient_test_pattern_defines.svh =====
// Assertion macros shared by the hue gradient pattern RTL
`ifndef HUE_GRADIENT_TEST_PATTERN_DEFINES_SVH
`define HUE_GRADIENT_TEST_PATTERN_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define HGTP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hgtp assertion failed");

// Next-cycle implication, clocked on clk, off while rst_n is low
`define HGTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hgtp assertion failed");

`endif

// ===== hdl/hgtp_pkg.sv =====
// Types and constants of the hue gradient test pattern generator
`default_nettype none

package hgtp_pkg;

    localparam int COLUMN_W = 10;
    localparam int ROW_W    = 9;
    localparam int LEVEL_W  = 8;

    // Raw red reaches 510 for columns past the nominal range
    localparam int RAW_W = 9;

    // Divider: numerator is raw*255, quotient never exceeds 255
    localparam int NUM_W         = 17;
    localparam int DEN_W         = RAW_W;
    localparam int DIV_STAGES    = 4;
    localparam int DIV_STEP_BITS = 2;
    localparam int QUO_W         = DIV_STAGES * DIV_STEP_BITS;

    // Pipeline stage indexes
    localparam int ST_LEVEL   = 0;
    localparam int ST_NUM     = 1;
    localparam int ST_DIV0    = 2;
    localparam int ST_OUT     = ST_DIV0 + DIV_STAGES;
    localparam int NUM_STAGES = ST_OUT + 1;

    localparam logic [COLUMN_W-1:0] LEVEL_FULL_X = 10'd255;
    localparam logic [COLUMN_W-1:0] GREEN_PEAK   = 10'd256;
    localparam logic [COLUMN_W-1:0] BLUE_PEAK    = 10'd512;
    localparam logic [COLUMN_W-1:0] RED_RISE     = 10'd513;
    localparam logic [COLUMN_W-1:0] ROW_MID      = 10'd256;
    localparam logic [LEVEL_W-1:0]  LEVEL_FULL   = 8'd255;

    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
    } coord_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } color_t;

endpackage

`default_nettype wire

// ===== hdl/hgtp_div.sv =====
// Pipelined restoring divider lane, quotient bits resolved two per stage
`default_nettype none

module hgtp_div (
    input  logic                           clk,
    input  logic [hgtp_pkg::DIV_STAGES-1:0] advance,
    input  logic [hgtp_pkg::NUM_W-1:0]      num,
    input  logic [hgtp_pkg::DEN_W-1:0]      den,
    output logic [hgtp_pkg::QUO_W-1:0]      quo
);
    import hgtp_pkg::*;

    logic [NUM_W-1:0] rem_reg [DIV_STAGES-1];
    logic [DEN_W-1:0] den_reg [DIV_STAGES-1];
    logic [QUO_W-1:0] quo_reg [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_stage
        localparam int LOW_POS = QUO_W - (j + 1) * DIV_STEP_BITS;

        logic [NUM_W-1:0]         rem_in;
        logic [DEN_W-1:0]         den_in;
        logic [QUO_W-1:0]         quo_in;
        logic [NUM_W-1:0]         rem_chain [DIV_STEP_BITS+1];
        logic [DIV_STEP_BITS-1:0] qbits;
        logic [QUO_W-1:0]         quo_next;

        if (j == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign rem_chain[0] = rem_in;

        // Subtract the shifted divisor where it fits, most significant bit first
        for (genvar s = 0; s < DIV_STEP_BITS; s++)
        begin : g_bit
            localparam int SHIFT = LOW_POS + DIV_STEP_BITS - 1 - s;
            logic [NUM_W-1:0] sub;
            assign sub = NUM_W'(den_in) << SHIFT;
            assign qbits[DIV_STEP_BITS-1-s] = (rem_chain[s] >= sub);
            assign rem_chain[s+1] = qbits[DIV_STEP_BITS-1-s] ? rem_chain[s] - sub
                                                               : rem_chain[s];
        end

        assign quo_next = quo_in | (QUO_W'(qbits) << LOW_POS);

        always_ff @(posedge clk)
        begin
            if (advance[j])
            begin
                quo_reg[j] <= quo_next;
            end
        end

        if (j < DIV_STAGES - 1)
        begin : g_keep
            logic [NUM_W-1:0] rem_next;
            assign rem_next = rem_chain[DIV_STEP_BITS];

            always_ff @(posedge clk)
            begin
                if (advance[j])
                begin
                    rem_reg[j] <= rem_next;
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/hue_gradient_test_pattern.sv =====
// A request passes the level, numerator, divider and output registers to its color.
// Throughput: one pixel per cycle unless the output stalls; the seven register stages
// advance independently, so empty stages close up behind a stalled output.
// Normalization runs through three 4-stage divider lanes, two quotient bits per stage.
// Reset clears only the stage valid bits; coord_ready is high once reset is released.
`default_nettype none

`include "hue_gradient_test_pattern_defines.svh"

module hue_gradient_test_pattern (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             coord_valid,
    output logic             coord_ready,
    input  hgtp_pkg::coord_t coord,
    output logic             color_valid,
    input  logic             color_ready,
    output hgtp_pkg::color_t color
);
    import hgtp_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             zero;
    } side_t;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] advance;
    logic [NUM_STAGES-1:0] feed;

    // ------------------------------------------------------------------ control
    assign advance[ST_OUT] = !valid_reg[ST_OUT] || color_ready;
    for (genvar i = 0; i < ST_OUT; i++)
    begin : g_adv
        assign advance[i] = !valid_reg[i] || advance[i+1];
    end

    assign feed       = {valid_reg[NUM_STAGES-2:0], coord_valid};
    assign valid_next = (advance & feed) | (~advance & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign coord_ready = advance[ST_LEVEL];

    // ------------------------------------------------------------ raw levels
    logic [COLUMN_W-1:0] x;
    logic [COLUMN_W-1:0] diff_g;
    logic [COLUMN_W-1:0] diff_b;
    logic [RAW_W-1:0]    r_next, r_reg;
    logic [RAW_W-1:0]    g_next, g_reg;
    logic [RAW_W-1:0]    b_next, b_reg;

    assign x = coord.column;

    always_comb
    begin
        if (x <= LEVEL_FULL_X)
        begin
            r_next = RAW_W'(LEVEL_FULL_X - x);
        end
        else if (x > RED_RISE)
        begin
            r_next = RAW_W'(x - RED_RISE);
        end
        else
        begin
            r_next = '0;
        end

        diff_g = (x < GREEN_PEAK) ? GREEN_PEAK - x : x - GREEN_PEAK;
        diff_b = (x < BLUE_PEAK) ? BLUE_PEAK - x : x - BLUE_PEAK;
        g_next = (diff_g <= LEVEL_FULL_X) ? RAW_W'(LEVEL_FULL_X - diff_g) : '0;
        b_next = (diff_b <= LEVEL_FULL_X) ? RAW_W'(LEVEL_FULL_X - diff_b) : '0;
    end

    side_t side_reg [ST_OUT];

    always_ff @(posedge clk)
    begin
        if (advance[ST_LEVEL])
        begin
            r_reg              <= r_next;
            g_reg              <= g_next;
            b_reg              <= b_next;
            side_reg[ST_LEVEL] <= '{row: coord.row, zero: 1'b0};
        end
    end

    // ------------------------------------------------ maximum and numerators
    logic [RAW_W-1:0] m_next;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] num_r_next, num_r_reg;
    logic [NUM_W-1:0] num_g_next, num_g_reg;
    logic [NUM_W-1:0] num_b_next, num_b_reg;

    always_comb
    begin
        m_next = r_reg;
        if (g_reg > m_next)
        begin
            m_next = g_reg;
        end
        if (b_reg > m_next)
        begin
            m_next = b_reg;
        end
        // times 255 as (c << 8) - c
        num_r_next = (NUM_W'(r_reg) << LEVEL_W) - NUM_W'(r_reg);
        num_g_next = (NUM_W'(g_reg) << LEVEL_W) - NUM_W'(g_reg);
        num_b_next = (NUM_W'(b_reg) << LEVEL_W) - NUM_W'(b_reg);
    end

    always_ff @(posedge clk)
    begin
        if (advance[ST_NUM])
        begin
            num_r_reg        <= num_r_next;
            num_g_reg        <= num_g_next;
            num_b_reg        <= num_b_next;
            den_reg          <= m_next;
            side_reg[ST_NUM] <= '{row: side_reg[ST_LEVEL].row, zero: (m_next == '0)};
        end
    end

    // ----------------------------------------------------------- normalize
    logic [QUO_W-1:0] quo_r, quo_g, quo_b;

    hgtp_div u_div_red (
        .clk     (clk),
        .advance (advance[ST_OUT-1:ST_DIV0]),
        .num     (num_r_reg),
        .den     (den_reg),
        .quo     (quo_r)
    );

    hgtp_div u_div_green (
        .clk     (clk),
        .advance (advance[ST_OUT-1:ST_DIV0]),
        .num     (num_g_reg),
        .den     (den_reg),
        .quo     (quo_g)
    );

    hgtp_div u_div_blue (
        .clk     (clk),
        .advance (advance[ST_OUT-1:ST_DIV0]),
        .num     (num_b_reg),
        .den     (den_reg),
        .quo     (quo_b)
    );

    // Carry row and the zero-maximum flag alongside the divider stages
    for (genvar i = ST_DIV0; i < ST_OUT; i++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (advance[i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------ row offset, output
    function automatic logic [LEVEL_W-1:0] add_offset(
        input logic [QUO_W-1:0] q,
        input logic [ROW_W-1:0] row
    );
        logic [COLUMN_W-1:0] lifted;
        logic [COLUMN_W-1:0] diff;
        lifted = COLUMN_W'(q) + ROW_MID;
        diff   = lifted - COLUMN_W'(row);
        if (lifted < COLUMN_W'(row))
        begin
            return '0;
        end
        else if (diff > LEVEL_FULL_X)
        begin
            return LEVEL_FULL;
        end
        else
        begin
            return LEVEL_W'(diff);
        end
    endfunction

    side_t            side_last;
    logic [QUO_W-1:0] qr_eff, qg_eff, qb_eff;
    color_t           color_next, color_reg;

    assign side_last = side_reg[ST_OUT-1];

    always_comb
    begin
        qr_eff           = side_last.zero ? '0 : quo_r;
        qg_eff           = side_last.zero ? '0 : quo_g;
        qb_eff           = side_last.zero ? '0 : quo_b;
        color_next.red   = add_offset(qr_eff, side_last.row);
        color_next.green = add_offset(qg_eff, side_last.row);
        color_next.blue  = add_offset(qb_eff, side_last.row);
    end

    always_ff @(posedge clk)
    begin
        if (advance[ST_OUT])
        begin
            color_reg <= color_next;
        end
    end

    assign color       = color_reg;
    assign color_valid = valid_reg[ST_OUT];

    // ------------------------------------------------------------ assertions
    // An empty output stage lets every stage advance
    `HGTP_ASSERT_NOW(a_ready_when_drained, !valid_reg[ST_OUT], coord_ready)
    // Some raw level is always nonzero for any column
    `HGTP_ASSERT_NOW(a_max_nonzero, valid_reg[ST_DIV0], !side_reg[ST_DIV0].zero)
    // The largest level normalizes to full scale
    `HGTP_ASSERT_NOW(a_peak_full, valid_reg[ST_OUT-1] && !side_last.zero,
        (quo_r == LEVEL_FULL) || (quo_g == LEVEL_FULL) || (quo_b == LEVEL_FULL))
    // A held output stage keeps its valid bit
    `HGTP_ASSERT_NEXT(a_hold_stalled, valid_reg[ST_OUT] && !color_ready, valid_reg[ST_OUT])

endmodule

`default_nettype wire
